@@ rtl/core/capillary_pressure_from_saturation_core_defines.svh @@
// Assertion macros for the capillary pressure core.
// Included by the top level; expects clk and rst_n in scope.
`ifndef CAPILLARY_PRESSURE_FROM_SATURATION_CORE_DEFINES_SVH
`define CAPILLARY_PRESSURE_FROM_SATURATION_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CPFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CPFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cpfs_pkg.sv @@
// Package for the capillary pressure core: widths, codes, item types,
// stage schedule and the per-stage arithmetic functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpfs_pkg;

  localparam int SAT_W         = 16;
  localparam int PRESS_W       = 47;
  localparam int RES_W         = 48;
  localparam int LAM_W         = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 47;
  localparam int SAT_FRAC_BITS = 15;
  localparam int LAM_FRAC      = 12;
  localparam int LOG_FRAC      = 20;

  // Operation codes.
  localparam logic [1:0] OP_VALUE  = 2'd0;
  localparam logic [1:0] OP_DERIV1 = 2'd1;
  localparam logic [1:0] OP_DERIV2 = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Status codes.
  localparam logic [1:0] STS_OK  = 2'd0;
  localparam logic [1:0] STS_SAT = 2'd1;
  localparam logic [1:0] STS_BAD = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RESID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CEIL  = 3'd4;

  // Register reset values.
  localparam logic [SAT_W-1:0]   RST_RESID = 16'd0;
  localparam logic [SAT_W-1:0]   RST_MAXS  = 16'd32768;
  localparam logic [PRESS_W-1:0] RST_ENTRY = 47'd65536000;
  localparam logic [LAM_W-1:0]   RST_LAM   = 16'd8192;
  localparam logic [PRESS_W-1:0] RST_CEIL  = 47'h7FFF_FFFF_FFFF;

  localparam logic [RES_W-1:0] POS_LIM = 48'h7FFF_FFFF_FFFF;
  localparam logic [RES_W-1:0] NEG_LIM = 48'h8000_0000_0000;
  localparam logic signed [19:0] X_DIV_ADJ = 20'(LAM_FRAC + SAT_FRAC_BITS);
  localparam logic signed [19:0] X_MUL_ADJ = 20'(SAT_FRAC_BITS);
  localparam logic signed [19:0] X_MANT    = 20'sd16;

  // Stage schedule: stage i turns pipeline register i into register i+1.
  localparam int LOG_FIRST  = 0;
  localparam int LOG_N      = LOG_FRAC;
  localparam int T_STG      = LOG_FIRST + LOG_N;
  localparam int YDIV_FIRST = T_STG + 1;
  localparam int YDIV_N     = 18;
  localparam int Y_STG      = YDIV_FIRST + YDIV_N;
  localparam int EXP_FIRST  = Y_STG + 1;
  localparam int EXP_N      = LOG_FRAC;
  localparam int MUL_STG    = EXP_FIRST + EXP_N;
  localparam int NORM1A     = MUL_STG + 1;
  localparam int NORM1B     = NORM1A + 1;
  localparam int DIV1_FIRST = NORM1B + 1;
  localparam int DIV_N      = 32;
  localparam int D1_STG     = DIV1_FIRST + DIV_N;
  localparam int MUL2_STG   = D1_STG + 1;
  localparam int NORM2A     = MUL2_STG + 1;
  localparam int NORM2B     = NORM2A + 1;
  localparam int DIV2_FIRST = NORM2B + 1;
  localparam int FIN_STG    = DIV2_FIRST + DIV_N;
  localparam int NSTG       = FIN_STG + 1;

  typedef struct packed {
    logic [1:0]       operation;
    logic [SAT_W-1:0] saturation;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result;
    logic [1:0]              status;
  } out_item_t;

  typedef struct packed {
    logic [SAT_W-1:0]   resid;
    logic [SAT_W-1:0]   maxs;
    logic [PRESS_W-1:0] entry;
    logic [LAM_W-1:0]   lam;
    logic [PRESS_W-1:0] ceil;
  } cfg_t;

  typedef struct packed {
    logic [31:0] m;
    logic [23:0] lg;
  } log_t;

  typedef struct packed {
    logic              sat;
    logic [RES_W-1:0]  v;
  } sat_res_t;

  // Everything one item carries down the pipeline.
  typedef struct packed {
    logic [1:0]         op;
    logic               fix;
    logic [RES_W-1:0]   fix_res;
    logic [1:0]         fix_sts;
    logic [SAT_W-1:0]   d;
    logic [LAM_W-1:0]   lam;
    log_t               ld;
    log_t               lb;
    logic [35:0]        y;
    logic [31:0]        acc;
    logic [63:0]        n;
    logic signed [19:0] x;
    logic [31:0]        rem;
    logic [31:0]        dv;
    logic [RES_W-1:0]   res;
    logic [1:0]         sts;
  } pipe_t;

  // Truncating integer square root, used at elaboration only.
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] a;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    a = v;
    for (int i = 0; i < 32; i++) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q1.30 root 2^(2^-j), by repeated square roots of two.
  function automatic logic [31:0] exp_root(int j);
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int k = 1; k <= LOG_FRAC; k++) begin
      if (k <= j) begin
        r = isqrt64(r << 30);
      end
    end
    return r[31:0];
  endfunction

  // Start of log2: exponent from the top set bit and Q1.30 mantissa.
  function automatic log_t log_init(logic [SAT_W-1:0] v);
    log_t o;
    logic [3:0] e;
    e = '0;
    for (int b = 0; b < SAT_W; b++) begin
      if (v[b]) begin
        e = 4'(b);
      end
    end
    o.m = 32'(v) << (5'd30 - 5'(e));
    o.lg = 24'(e);
    return o;
  endfunction

  // One fraction bit of log2 by squaring the mantissa.
  function automatic log_t log_step(log_t l);
    log_t o;
    logic [63:0] p;
    logic [31:0] sq;
    p = 64'(l.m) * 64'(l.m);
    sq = p[61:30];
    if (sq[31]) begin
      o.m = {1'b0, sq[31:1]};
      o.lg = {l.lg[22:0], 1'b1};
    end else begin
      o.m = sq;
      o.lg = {l.lg[22:0], 1'b0};
    end
    return o;
  endfunction

  // Two restoring division steps; the quotient shifts into n from below.
  function automatic pipe_t div_pair(pipe_t s);
    pipe_t o;
    logic [32:0] r2;
    o = s;
    for (int k = 0; k < 2; k++) begin
      r2 = {o.rem, o.n[63]};
      o.n = o.n << 1;
      if (r2 >= {1'b0, o.dv}) begin
        r2 = r2 - {1'b0, o.dv};
        o.n[0] = 1'b1;
      end
      o.rem = r2[31:0];
    end
    return o;
  endfunction

  // floor(n * 2^x), saturating at lim.
  function automatic sat_res_t scale_sat(logic [63:0] n, logic signed [19:0] x,
                                         logic [RES_W-1:0] lim);
    sat_res_t o;
    logic [19:0] sh;
    logic [63:0] v;
    logic [63:0] lim_sh;
    o.sat = 1'b0;
    o.v = '0;
    sh = '0;
    v = '0;
    lim_sh = '0;
    if (n != '0) begin
      if (x < 0) begin
        sh = 20'(-x);
        v = (sh >= 20'd64) ? '0 : (n >> sh[5:0]);
        if (v > 64'(lim)) begin
          o.sat = 1'b1;
          v = 64'(lim);
        end
        o.v = v[RES_W-1:0];
      end else if (x >= 20'sd64) begin
        o.sat = 1'b1;
        o.v = lim;
      end else begin
        lim_sh = 64'(lim) >> x[5:0];
        if (n > lim_sh) begin
          o.sat = 1'b1;
          o.v = lim;
        end else begin
          v = n << x[5:0];
          o.v = v[RES_W-1:0];
        end
      end
    end
    return o;
  endfunction

  // Coarse half of the left normalization.
  function automatic pipe_t norm_hi(pipe_t s);
    pipe_t o;
    o = s;
    if (o.n[63:32] == '0) begin
      o.n = o.n << 32;
      o.x = o.x - 20'sd32;
    end
    if (o.n[63:48] == '0) begin
      o.n = o.n << 16;
      o.x = o.x - 20'sd16;
    end
    if (o.n[63:56] == '0) begin
      o.n = o.n << 8;
      o.x = o.x - 20'sd8;
    end
    return o;
  endfunction

  // Fine half of the left normalization; clears the divider remainder.
  function automatic pipe_t norm_lo(pipe_t s);
    pipe_t o;
    o = s;
    if (o.n[63:60] == '0) begin
      o.n = o.n << 4;
      o.x = o.x - 20'sd4;
    end
    if (o.n[63:62] == '0) begin
      o.n = o.n << 2;
      o.x = o.x - 20'sd2;
    end
    if (!o.n[63]) begin
      o.n = o.n << 1;
      o.x = o.x - 20'sd1;
    end
    o.rem = '0;
    return o;
  endfunction

  // Front stage: clamp, special cases and log2 setup.
  function automatic pipe_t prep_fn(in_item_t it, cfg_t c);
    pipe_t o;
    logic [SAT_W-1:0] s;
    o = '0;
    o.op = it.operation;
    s = it.saturation;
    if (s < c.resid) begin
      s = c.resid;
    end
    if (s > c.maxs) begin
      s = c.maxs;
    end
    o.d = s - c.resid;
    o.lam = (c.lam == '0) ? 16'd1 : c.lam;
    o.ld = log_init(o.d);
    o.lb = log_init(c.maxs - c.resid);
    if (c.resid >= c.maxs) begin
      o.fix = 1'b1;
      o.fix_sts = STS_BAD;
    end else if (it.operation == OP_UNUSED || c.entry == '0) begin
      o.fix = 1'b1;
      o.fix_sts = STS_OK;
    end else if (o.d == '0) begin
      o.fix = 1'b1;
      o.fix_sts = STS_SAT;
      case (it.operation)
        OP_VALUE:  o.fix_res = 48'(c.ceil);
        OP_DERIV1: o.fix_res = NEG_LIM;
        default:   o.fix_res = POS_LIM;
      endcase
    end
    return o;
  endfunction

  // Work of pipeline stage idx.
  function automatic pipe_t stage_fn(int idx, pipe_t s, cfg_t c, logic [31:0] root);
    pipe_t o;
    sat_res_t sr;
    logic [63:0] prod;
    logic signed [19:0] xa;
    logic [4:0] sh;
    int bi;
    o = s;
    sr = '0;
    prod = '0;
    xa = '0;
    sh = '0;
    bi = 0;
    if (idx >= LOG_FIRST && idx < LOG_FIRST + LOG_N) begin
      o.ld = log_step(s.ld);
      o.lb = log_step(s.lb);
    end else if (idx == T_STG) begin
      // t = log2(D) - log2(d), placed at the top of the dividend.
      o.n = {s.lb.lg - s.ld.lg, 40'd0};
      o.rem = '0;
      o.dv = 32'(s.lam);
    end else if ((idx >= YDIV_FIRST && idx < YDIV_FIRST + YDIV_N) ||
                 (idx >= DIV1_FIRST && idx < DIV1_FIRST + DIV_N) ||
                 (idx >= DIV2_FIRST && idx < DIV2_FIRST + DIV_N)) begin
      o = div_pair(s);
    end else if (idx == Y_STG) begin
      o.y = s.n[35:0];
      o.acc = 32'h4000_0000;
    end else if (idx >= EXP_FIRST && idx < EXP_FIRST + EXP_N) begin
      bi = LOG_FRAC - 1 - (idx - EXP_FIRST);
      if (s.y[bi]) begin
        prod = 64'(s.acc) * 64'(root);
        o.acc = prod[61:30];
      end
    end else if (idx == MUL_STG) begin
      o.n = 64'(c.entry) * 64'(s.acc[30:14]);
      o.x = $signed({4'd0, s.y[35:20]}) - X_MANT;
      o.dv = 32'(s.lam) * 32'(s.d);
    end else if (idx == NORM1A || idx == NORM2A) begin
      o = norm_hi(s);
      if (idx == NORM1A && s.op == OP_VALUE) begin
        sr = scale_sat(s.n, s.x, POS_LIM);
        o.res = (sr.v > 48'(c.ceil)) ? 48'(c.ceil) : sr.v;
        o.sts = sr.sat ? STS_SAT : STS_OK;
      end
    end else if (idx == NORM1B || idx == NORM2B) begin
      o = norm_lo(s);
    end else if (idx == D1_STG) begin
      xa = s.x + X_DIV_ADJ;
      if (s.op == OP_DERIV1) begin
        sr = scale_sat(s.n, xa, NEG_LIM);
        o.res = 48'd0 - sr.v;
        o.sts = sr.sat ? STS_SAT : STS_OK;
      end
      // Shift right until the quotient fits 47 bits.
      for (int b = 47; b < 64; b++) begin
        if (s.n[b]) begin
          sh = 5'(b - 46);
        end
      end
      o.n = s.n >> sh;
      o.x = xa + $signed({15'd0, sh});
    end else if (idx == MUL2_STG) begin
      o.n = 64'(s.n[46:0]) * 64'(17'(s.lam) + 17'd4096);
      o.x = s.x + X_MUL_ADJ;
    end else if (idx == FIN_STG) begin
      if (s.op == OP_DERIV2) begin
        sr = scale_sat(s.n, s.x, POS_LIM);
        o.res = sr.v;
        o.sts = sr.sat ? STS_SAT : STS_OK;
      end
      if (s.fix) begin
        o.res = s.fix_res;
        o.sts = s.fix_sts;
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/capillary_pressure_from_saturation_core.sv @@
// Brooks-Corey capillary pressure core: config registers and pipeline.
// Depends on cpfs_pkg and capillary_pressure_from_saturation_core_defines.svh.
//
// Usage: items (operation, saturation) enter on the in_ valid/ready channel;
// each yields exactly one (result, status) item on the out_ channel, in order.
// Registers are written through cfg_we/cfg_index/cfg_data, by the user only
// while idle; the block does not enforce this. An accepted item passes a front
// stage, 132 arithmetic stages (log2 squaring, three restoring dividers at two
// quotient bits per stage, exp2 root products, normalizing shifts) and the
// output register. Throughput is one item per cycle; the two 64/32 dividers
// set the depth. When the receiver stalls with a result waiting, the whole
// pipeline holds and in_ready drops; nothing is lost or repeated. Reset clears
// the valid bits and the output valid and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module capillary_pressure_from_saturation_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire cpfs_pkg::in_item_t                  in_data,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      cpfs_pkg::out_item_t                 out_data,
  input  wire logic                                cfg_we,
  input  wire logic [cpfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cpfs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cpfs_pkg::*;

  logic [SAT_W-1:0]   resid_r;
  logic [SAT_W-1:0]   maxs_r;
  logic [PRESS_W-1:0] entry_r;
  logic [LAM_W-1:0]   lam_r;
  logic [PRESS_W-1:0] ceil_r;
  cfg_t               cfg;
  logic               adv;
  logic [NSTG:0]      vld_r;
  pipe_t              stg_r [NSTG+1];
  logic               out_valid_r;
  out_item_t          out_data_r;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resid_r <= RST_RESID;
      maxs_r  <= RST_MAXS;
      entry_r <= RST_ENTRY;
      lam_r   <= RST_LAM;
      ceil_r  <= RST_CEIL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESID: resid_r <= cfg_data[SAT_W-1:0];
        CFG_MAXS:  maxs_r  <= cfg_data[SAT_W-1:0];
        CFG_ENTRY: entry_r <= cfg_data;
        CFG_LAM:   lam_r   <= cfg_data[LAM_W-1:0];
        CFG_CEIL:  ceil_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg.resid = resid_r;
  assign cfg.maxs  = maxs_r;
  assign cfg.entry = entry_r;
  assign cfg.lam   = lam_r;
  assign cfg.ceil  = ceil_r;

  // The pipeline advances unless a finished item is stuck at the output.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-1:0], in_valid};
    end
  end

  // Front stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r[0] <= prep_fn(in_data, cfg);
    end
  end

  // Arithmetic stages.
  for (genvar gi = 0; gi < NSTG; gi++) begin : g_stage
    localparam logic [31:0] ROOT = exp_root(gi - EXP_FIRST + 1);
    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[gi+1] <= stage_fn(gi, stg_r[gi], cfg, ROOT);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.result <= $signed(stg_r[NSTG].res);
      out_data_r.status <= stg_r[NSTG].sts;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `include "capillary_pressure_from_saturation_core_defines.svh"

  `CPFS_ASSERT_NXT(a_stall_freeze, !in_ready, $stable(vld_r) && out_valid_r, "pipeline moved during a stall")
  `CPFS_ASSERT_NXT(a_out_load, in_ready && vld_r[NSTG], out_valid_r, "finished item not loaded into output")
  `CPFS_ASSERT_IMP(a_bad_zero, out_valid_r && (out_data_r.status == STS_BAD), out_data_r.result == '0, "bad configuration item has nonzero result")
  `CPFS_ASSERT_IMP(a_bad_src, out_valid_r && (out_data_r.status == STS_BAD), resid_r >= maxs_r, "bad configuration status with valid bounds")

endmodule

`default_nettype wire

@@ dv/capillary_pressure_from_saturation_core_tb.sv @@
// Self-checking testbench for the Brooks-Corey capillary pressure core.
// Depends on cpfs_pkg and capillary_pressure_from_saturation_core.
// Items are predicted in fixed point and compared in order with the results.
`timescale 1ns / 1ps

module capillary_pressure_from_saturation_core_tb;
  import cpfs_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 320;
  localparam int DRAIN_WAIT  = 160;
  localparam logic [63:0] MASK47 = (64'd1 << 47) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  capillary_pressure_from_saturation_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the configuration registers.
  logic [63:0] sh_resid = 64'(RST_RESID);
  logic [63:0] sh_maxs  = 64'(RST_MAXS);
  logic [63:0] sh_entry = 64'(RST_ENTRY);
  logic [63:0] sh_lam   = 64'(RST_LAM);
  logic [63:0] sh_ceil  = 64'(RST_CEIL);
  logic [63:0] exp_roots [1:20];

  in_item_t  pending_items[$];
  out_item_t expected_pc[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;
  int  hold_req = 0;
  int  hold_seen = 0;
  bit  in_took = 1'b0;
  int  in_gap = 0;
  int  out_stall = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // Q.20 log2 of a raw integer, by repeated squaring of the mantissa.
  function automatic logic [63:0] log2_q20(logic [15:0] v);
    int e;
    logic [63:0] m, bits;
    e = 15;
    while (e > 0 && !v[e]) e--;
    m = 64'(v) << (30 - e);
    bits = 0;
    for (int i = 0; i < 20; i++) begin
      m = (m * m) >> 30;
      bits = bits << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        bits = bits | 1;
      end
    end
    return (64'(e) << 20) | bits;
  endfunction

  // floor(n * 2^x), saturating at lim.
  function automatic logic [63:0] scale_to(logic [63:0] n, int x, logic [63:0] lim,
                                           inout bit sat);
    logic [63:0] v;
    if (n == 0) return 0;
    if (x < 0) begin
      v = (x <= -64) ? 64'd0 : (n >> (-x));
    end else if (x >= 64 || n > (lim >> x)) begin
      sat = 1'b1;
      return lim;
    end else begin
      v = n << x;
    end
    if (v > lim) begin
      sat = 1'b1;
      v = lim;
    end
    return v;
  endfunction

  function automatic void normalize(inout logic [63:0] n, inout int x);
    if (n == 0) return;
    while (!n[63]) begin
      n = n << 1;
      x--;
    end
  endfunction

  // Expected pressure or derivative for one item under the shadow configuration.
  function automatic out_item_t predict_pc(in_item_t it);
    out_item_t o;
    logic [63:0] s, d, lam, t, y, acc, n, dv, v;
    int x;
    bit sat;
    o = '0;
    sat = 1'b0;
    if (sh_resid >= sh_maxs) begin
      o.status = STS_BAD;
      return o;
    end
    if (it.operation == OP_UNUSED || sh_entry == 0) return o;
    s = 64'(it.saturation);
    if (s < sh_resid) s = sh_resid;
    if (s > sh_maxs) s = sh_maxs;
    d = s - sh_resid;
    lam = (sh_lam == 0) ? 64'd1 : sh_lam;
    // Saturation at the residual bound gives an infinite pressure.
    if (d == 0) begin
      o.status = STS_SAT;
      case (it.operation)
        OP_VALUE:  o.result = 48'(sh_ceil);
        OP_DERIV1: o.result = NEG_LIM;
        default:   o.result = POS_LIM;
      endcase
      return o;
    end
    t = log2_q20(16'(sh_maxs - sh_resid)) - log2_q20(16'(d));
    y = (t << 12) / lam;
    acc = 64'h4000_0000;
    for (int i = 1; i <= 20; i++) begin
      if (y[20 - i]) acc = (acc * exp_roots[i]) >> 30;
    end
    n = sh_entry * (acc >> 14);
    x = int'(y >> 20) - 16;
    if (it.operation == OP_VALUE) begin
      v = scale_to(n, x, 64'(POS_LIM), sat);
      if (v > sh_ceil) v = sh_ceil;
      o.result = 48'(v);
      o.status = sat ? STS_SAT : STS_OK;
      return o;
    end
    dv = lam * d;
    normalize(n, x);
    n = n / dv;
    x = x + 12 + SAT_FRAC_BITS;
    if (it.operation == OP_DERIV1) begin
      v = scale_to(n, x, 64'(NEG_LIM), sat);
      o.result = 48'(64'd0 - v);
    end else begin
      while (n >> 47) begin
        n = n >> 1;
        x++;
      end
      n = n * (lam + 64'd4096);
      x = x + SAT_FRAC_BITS;
      normalize(n, x);
      n = n / dv;
      o.result = 48'(scale_to(n, x, 64'(POS_LIM), sat));
    end
    o.status = sat ? STS_SAT : STS_OK;
    return o;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sender: presents the next pending item once the previous one is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold when one is requested.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_stall = LONG_HOLD;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_stall = pick_gap();
        out_ready <= (out_stall == 0);
      end
    end
  end

  // Monitor: predicts on input handshakes, checks on output handshakes.
  always @(posedge clk) begin
    out_item_t want;
    in_took = rst_n && in_valid && in_ready;
    if (in_took) expected_pc.push_back(predict_pc(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (expected_pc.size() == 0) begin
        $error("unexpected result item %h", out_data);
        errors++;
      end else begin
        want = expected_pc.pop_front();
        if (out_data.result !== want.result) begin
          $error("result: expected %h, got %h", want.result, out_data.result);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((rst_n && in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    case (idx)
      CFG_RESID: sh_resid = val & 64'hFFFF;
      CFG_MAXS:  sh_maxs  = val & 64'hFFFF;
      CFG_ENTRY: sh_entry = val & MASK47;
      CFG_LAM:   sh_lam   = val & 64'hFFFF;
      CFG_CEIL:  sh_ceil  = val & MASK47;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_pc.size() != 0)
      @(negedge clk);
  endtask

  task automatic add_item(logic [1:0] op, logic [15:0] sat);
    in_item_t it;
    it.operation = op;
    it.saturation = sat;
    pending_items.push_back(it);
  endtask

  // Random items, most within the physical range, some near the bounds.
  task automatic add_random(int count);
    logic [15:0] sat;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0:       sat = 16'($urandom_range(0, 65535));
        1:       sat = 16'(sh_resid + $urandom_range(0, 3));
        2:       sat = 16'(sh_maxs - $urandom_range(0, 3));
        default: sat = 16'($urandom_range(0, 32768));
      endcase
      add_item(2'($urandom_range(0, 3)), sat);
    end
  endtask

  function automatic logic [63:0] rand47();
    return ({32'($urandom), 32'($urandom)} & MASK47) >> $urandom_range(0, 46);
  endfunction

  task automatic random_config();
    logic [63:0] r, m;
    r = $urandom_range(0, 32000);
    m = $urandom_range(r + 1, 32768);
    if ($urandom_range(0, 7) == 0) m = r;
    write_reg(CFG_RESID, r);
    write_reg(CFG_MAXS, m);
    write_reg(CFG_ENTRY, ($urandom_range(0, 9) == 0) ? 64'd0 : rand47());
    write_reg(CFG_LAM, ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 65535))
                                                   : 64'($urandom_range(400, 20000)));
    write_reg(CFG_CEIL, ($urandom_range(0, 1) == 0) ? MASK47 : rand47());
  endtask

  initial begin
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int i = 1; i <= 20; i++) begin
      r = int_sqrt(r << 30);
      exp_roots[i] = r;
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset configuration: bounds and every operation.
    for (int op = 0; op < 4; op++) begin
      add_item(2'(op), 16'd0);
      add_item(2'(op), 16'd32768);
      add_item(2'(op), 16'd65535);
      add_item(2'(op), 16'd1);
    end
    add_item(OP_VALUE, 16'd16384);
    add_item(OP_DERIV1, 16'h5555);
    add_item(OP_DERIV2, 16'h2AAA);
    add_item(OP_VALUE, 16'h7FFF);
    wait_drained();

    // Extremes: full entry pressure, smallest lambda, zero ceiling.
    write_reg(CFG_RESID, 0);
    write_reg(CFG_MAXS, 32768);
    write_reg(CFG_ENTRY, MASK47);
    write_reg(CFG_LAM, 1);
    write_reg(CFG_CEIL, 0);
    add_random(30);
    wait_drained();

    // Largest lambda, zero lambda, and narrow bounds.
    write_reg(CFG_RESID, 32767);
    write_reg(CFG_MAXS, 32768);
    write_reg(CFG_LAM, 65535);
    write_reg(CFG_CEIL, MASK47);
    add_random(15);
    wait_drained();
    write_reg(CFG_RESID, 1000);
    write_reg(CFG_LAM, 0);
    write_reg(CFG_ENTRY, 64'd1);
    add_random(15);
    wait_drained();

    // Bad configuration: residual above maximum.
    write_reg(CFG_RESID, 32768);
    write_reg(CFG_MAXS, 0);
    add_random(10);
    wait_drained();

    // Back pressure: a long receiver hold while the sender keeps offering.
    write_reg(CFG_RESID, 3277);
    write_reg(CFG_MAXS, 29491);
    write_reg(CFG_ENTRY, 64'd6553600);
    write_reg(CFG_LAM, 4096);
    write_reg(CFG_CEIL, 64'd327680000);
    no_idle = 1'b1;
    hold_req++;
    add_random(170);
    wait_drained();
    no_idle = 1'b0;

    for (int p = 0; p < 7; p++) begin
      random_config();
      no_idle = (p == 3);
      add_random(30);
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && expected_pc.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
